// File: design/cuckoo_hash_table_assert.svh
// Assertion macros used by the cuckoo hash table checker
`ifndef CUCKOO_HASH_TABLE_ASSERT_SVH
`define CUCKOO_HASH_TABLE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define CHT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cht_pkg.sv
// Types, codes and constants of the cuckoo hash table
package cht_pkg;

  localparam int KEY_W          = 31;
  localparam int SLOT_W         = KEY_W + 1;
  localparam int KICK_W         = 12;
  localparam int TABLE_SIZE_DEF = 1024;

  localparam logic [KICK_W-1:0] KICKS_RESET = 12'd1000;

  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_PRESENT  = 2'd2;
  localparam logic [1:0] ST_DROPPED  = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
  } cht_req_t;

  typedef struct packed {
    logic             found;
    logic [1:0]       status;
    logic [KEY_W-1:0] dropped_key;
  } cht_rsp_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOKUP,
    S_KICK,
    S_CLEAR,
    S_RESP
  } cht_state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_SEARCH,
    RES_PRESENT,
    RES_INSERTED,
    RES_DROP
  } cht_res_t;

  typedef struct packed {
    logic     take_req;
    logic     wr_first;
    logic     wr_second;
    logic     kick_start;
    logic     kick_swap;
    logic     kick_place;
    logic     clr_step;
    logic     res_load;
    cht_res_t res_sel;
    logic     out_load;
  } cht_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       hit;
    logic       first_empty;
    logic       second_empty;
    logic       cur_empty;
    logic       kick_limit;
    logic       clr_last;
    logic       out_free;
  } cht_sts_t;

endpackage

// File: design/cht_dp.sv
// Datapath of the cuckoo hash table: two half tables, eviction registers, result output
module cht_dp #(
  parameter int TABLE_SIZE = cht_pkg::TABLE_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cht_pkg::cht_req_t         in_req,
  input  logic                      cfg_wr_en,
  input  logic [cht_pkg::KICK_W-1:0] cfg_wr_data,
  input  cht_pkg::cht_ctl_t         ctl,
  output cht_pkg::cht_sts_t         sts,
  output logic                      out_valid,
  input  logic                      out_stall,
  output cht_pkg::cht_rsp_t         out_rsp
);
  import cht_pkg::*;

  localparam int HALF   = TABLE_SIZE / 2;
  localparam int HalfAw = $clog2(HALF);
  localparam int ExtW   = KEY_W + HalfAw;

  function automatic logic [HalfAw-1:0] first_idx(input logic [KEY_W-1:0] k);
    return k[HalfAw-1:0];
  endfunction

  function automatic logic [HalfAw-1:0] second_idx(input logic [KEY_W-1:0] k);
    logic [ExtW-1:0] ext;
    ext = ExtW'(k) >> HalfAw;
    return ext[HalfAw-1:0];
  endfunction

  logic [SLOT_W-1:0] lo_mem [HALF];
  logic [SLOT_W-1:0] hi_mem [HALF];

  logic [1:0]        cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  hand_r;
  logic              upper_r;
  logic [KICK_W-1:0] kicks_r;
  logic [KICK_W-1:0] max_kicks_r;
  logic [HalfAw-1:0] clr_cnt_r;
  logic [SLOT_W-1:0] lo_q_r;
  logic [SLOT_W-1:0] hi_q_r;
  cht_rsp_t          res_r;
  cht_rsp_t          res_nxt;
  logic              out_valid_r;
  cht_rsp_t          out_rsp_r;

  logic [SLOT_W-1:0] cur_slot;
  logic [KEY_W-1:0]  cur_key;
  logic              kick_wr;
  logic              out_free;

  logic              lo_we, hi_we, lo_re, hi_re;
  logic [HalfAw-1:0] lo_waddr, hi_waddr, lo_raddr, hi_raddr;
  logic [SLOT_W-1:0] lo_wdata, hi_wdata;

  assign cur_slot = upper_r ? hi_q_r : lo_q_r;
  assign cur_key  = cur_slot[KEY_W-1:0];
  assign kick_wr  = ctl.kick_swap || ctl.kick_place;
  assign out_free = !out_valid_r || !out_stall;

  // Write ports: clearing pass, direct insert, or the key in hand at the current slot
  always_comb begin
    lo_we    = 1'b0;
    lo_waddr = first_idx(hand_r);
    lo_wdata = {1'b1, hand_r};
    if (ctl.clr_step) begin
      lo_we    = 1'b1;
      lo_waddr = clr_cnt_r;
      lo_wdata = '0;
    end else if (ctl.wr_first) begin
      lo_we    = 1'b1;
      lo_waddr = first_idx(key_r);
      lo_wdata = {1'b1, key_r};
    end else if (kick_wr && !upper_r) begin
      lo_we    = 1'b1;
    end
  end

  always_comb begin
    hi_we    = 1'b0;
    hi_waddr = second_idx(hand_r);
    hi_wdata = {1'b1, hand_r};
    if (ctl.clr_step) begin
      hi_we    = 1'b1;
      hi_waddr = clr_cnt_r;
      hi_wdata = '0;
    end else if (ctl.wr_second) begin
      hi_we    = 1'b1;
      hi_waddr = second_idx(key_r);
      hi_wdata = {1'b1, key_r};
    end else if (kick_wr && upper_r) begin
      hi_we    = 1'b1;
    end
  end

  // Read ports: both slots of a new request, or the evicted key's slot in the other half
  always_comb begin
    lo_re    = 1'b0;
    hi_re    = 1'b0;
    lo_raddr = first_idx(in_req.key);
    hi_raddr = second_idx(in_req.key);
    if (ctl.take_req) begin
      lo_re = 1'b1;
      hi_re = 1'b1;
    end else if (ctl.kick_swap) begin
      if (upper_r) begin
        lo_re    = 1'b1;
        lo_raddr = first_idx(cur_key);
      end else begin
        hi_re    = 1'b1;
        hi_raddr = second_idx(cur_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lo_we) begin
      lo_mem[lo_waddr] <= lo_wdata;
    end
    if (lo_re) begin
      lo_q_r <= lo_mem[lo_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hi_we) begin
      hi_mem[hi_waddr] <= hi_wdata;
    end
    if (hi_re) begin
      hi_q_r <= hi_mem[hi_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_kicks_r <= KICKS_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_kicks_r <= cfg_wr_data;
      end
      if (ctl.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_req) begin
      cmd_r <= in_req.cmd;
      key_r <= in_req.key;
    end
    if (ctl.kick_start) begin
      hand_r  <= key_r;
      upper_r <= 1'b0;
      kicks_r <= '0;
    end else if (ctl.kick_swap) begin
      hand_r  <= cur_key;
      upper_r <= ~upper_r;
      kicks_r <= kicks_r + 1'b1;
    end
    if (ctl.res_load) begin
      res_r <= res_nxt;
    end
    if (ctl.out_load) begin
      out_rsp_r <= res_r;
    end
  end

  always_comb begin
    res_nxt = '0;
    case (ctl.res_sel)
      RES_NONE: begin
        res_nxt = '0;
      end
      RES_SEARCH: begin
        res_nxt.found = sts.hit;
      end
      RES_PRESENT: begin
        res_nxt.found  = 1'b1;
        res_nxt.status = ST_PRESENT;
      end
      RES_INSERTED: begin
        res_nxt.status = ST_INSERTED;
      end
      RES_DROP: begin
        res_nxt.status      = ST_DROPPED;
        res_nxt.dropped_key = hand_r;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_comb begin
    sts.cmd          = cmd_r;
    sts.hit          = (lo_q_r == {1'b1, key_r}) || (hi_q_r == {1'b1, key_r});
    sts.first_empty  = !lo_q_r[SLOT_W-1];
    sts.second_empty = !hi_q_r[SLOT_W-1];
    sts.cur_empty    = !cur_slot[SLOT_W-1];
    sts.kick_limit   = kicks_r >= max_kicks_r;
    sts.clr_last     = clr_cnt_r == HalfAw'(HALF - 1);
    sts.out_free     = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// File: design/cht_ctrl.sv
// Controller state machine of the cuckoo hash table
module cht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cht_pkg::cht_sts_t sts,
  output cht_pkg::cht_ctl_t ctl
);
  import cht_pkg::*;

  cht_state_t state_r;
  cht_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts.cmd == CMD_CLEAR) begin
          state_nxt = S_CLEAR;
        end else if (sts.cmd == CMD_INSERT && !sts.hit && !sts.first_empty
                     && !sts.second_empty) begin
          state_nxt = S_KICK;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_KICK: begin
        if (sts.cur_empty || sts.kick_limit) begin
          state_nxt = S_RESP;
        end
      end
      S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_INIT: begin
        ctl.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_stall     = 1'b0;
        ctl.take_req = in_valid;
      end
      S_LOOKUP: begin
        case (sts.cmd)
          CMD_SEARCH: begin
            ctl.res_load = 1'b1;
            ctl.res_sel  = RES_SEARCH;
          end
          CMD_INSERT: begin
            if (sts.hit) begin
              ctl.res_load = 1'b1;
              ctl.res_sel  = RES_PRESENT;
            end else if (sts.first_empty) begin
              ctl.wr_first = 1'b1;
              ctl.res_load = 1'b1;
              ctl.res_sel  = RES_INSERTED;
            end else if (sts.second_empty) begin
              ctl.wr_second = 1'b1;
              ctl.res_load  = 1'b1;
              ctl.res_sel   = RES_INSERTED;
            end else begin
              ctl.kick_start = 1'b1;
            end
          end
          CMD_CLEAR: begin
            ctl.res_sel = RES_NONE;
          end
          default: begin
            ctl.res_load = 1'b1;
            ctl.res_sel  = RES_NONE;
          end
        endcase
      end
      S_KICK: begin
        // place the key in hand, drop it at the limit, or evict and move on
        if (sts.cur_empty) begin
          ctl.kick_place = 1'b1;
          ctl.res_load   = 1'b1;
          ctl.res_sel    = RES_INSERTED;
        end else if (sts.kick_limit) begin
          ctl.res_load = 1'b1;
          ctl.res_sel  = RES_DROP;
        end else begin
          ctl.kick_swap = 1'b1;
        end
      end
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          ctl.res_load = 1'b1;
          ctl.res_sel  = RES_NONE;
        end
      end
      S_RESP: begin
        ctl.out_load = sts.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

// File: design/cuckoo_hash_table.sv
// Top level of the two-way cuckoo hash table
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------
//   request  | in_valid/in_stall   | in_req: cmd, key
//   result   | out_valid/out_stall | out_rsp: found, status, dropped_key
//   config   | cfg_wr_en           | cfg_wr_data: max_kicks
//
// Search, hit, direct insert and unused commands pass per request through accept,
// the lookup on the registered reads of both half tables, and the response.
// An insert that evicts adds a kick step per eviction, then a step to place or drop the key.
// A clear and the pass after reset sweep both halves, one row a cycle.
// in_stall stays high from reset release through the reset sweep, and whenever busy.
// A finished result waits in the output register; the response state holds on out_stall.
module cuckoo_hash_table #(
  parameter int TABLE_SIZE = cht_pkg::TABLE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cht_pkg::cht_req_t          in_req,
  input  logic                       cfg_wr_en,
  input  logic [cht_pkg::KICK_W-1:0] cfg_wr_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cht_pkg::cht_rsp_t          out_rsp
);
  import cht_pkg::*;

  cht_ctl_t ctl;
  cht_sts_t sts;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  cht_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_rsp     (out_rsp)
  );

endmodule

// File: design/cht_checker.sv
// Port-level checker of the cuckoo hash table and its bind
`include "cuckoo_hash_table_assert.svh"

module cht_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input cht_pkg::cht_rsp_t out_rsp
);
  import cht_pkg::*;

  `CHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rsp), "stalled result changed")

  `CHT_ASSERT_SAME(a_drop_zero, out_valid && (out_rsp.status != ST_DROPPED), out_rsp.dropped_key == '0, "dropped key set without kick limit")

  `CHT_ASSERT_SAME(a_found_code, out_valid && out_rsp.found, (out_rsp.status == ST_PRESENT) || (out_rsp.status == ST_DONE), "found set with insert or drop status")

  `CHT_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "request accepted while previous one in work")

endmodule

bind cuckoo_hash_table cht_checker u_cht_checker (.*);

// File: dv/cuckoo_hash_table_test.sv
// Self-checking testbench for the two-way cuckoo hash table
`timescale 1ns / 1ps

module cuckoo_hash_table_test;
  import cht_pkg::*;

  localparam int TSIZE = TABLE_SIZE_DEF;
  localparam int HALF = TSIZE / 2;
  localparam int HQ = HALF * HALF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RUN_LIMIT = 4_000_000;
  localparam int DRAIN_LIMIT = 20_000;
  localparam int MAX_REPORTS = 10;

  // Shadow copy of the hash set; predicts one response per request
  class cuckoo_shadow;
    logic [SLOT_W-1:0] slots [TSIZE];
    logic [KICK_W-1:0] kick_limit;
    cht_rsp_t owed_rsps [$];
    int mismatches, searches, hits, inserts, evict_inserts, drops, clears, unused;

    function new();
      wipe();
      kick_limit = KICKS_RESET;
    endfunction

    function void wipe();
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int first_of(logic [KEY_W-1:0] k);
      return int'(k % HALF);
    endfunction

    function int second_of(logic [KEY_W-1:0] k);
      return HALF + int'((k / HALF) % HALF);
    endfunction

    function bit holds(int idx, logic [KEY_W-1:0] k);
      return slots[idx] == {1'b1, k};
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endfunction

    function void apply_request(cht_req_t r);
      cht_rsp_t rsp;
      int p1, p2, idx, kicks;
      logic [KEY_W-1:0] hand, evicted;
      bit upper, gave_up;
      rsp = '0;
      p1 = first_of(r.key);
      p2 = second_of(r.key);
      case (r.cmd)
        CMD_SEARCH: begin
          searches++;
          rsp.found = holds(p1, r.key) || holds(p2, r.key);
          if (rsp.found) hits++;
        end
        CMD_INSERT: begin
          inserts++;
          if (holds(p1, r.key) || holds(p2, r.key)) begin
            rsp.found = 1'b1;
            rsp.status = ST_PRESENT;
          end else if (!slots[p1][KEY_W]) begin
            slots[p1] = {1'b1, r.key};
            rsp.status = ST_INSERTED;
          end else if (!slots[p2][KEY_W]) begin
            slots[p2] = {1'b1, r.key};
            rsp.status = ST_INSERTED;
          end else begin
            // evict, alternating halves, until a hole turns up or the limit is hit
            hand = r.key;
            idx = p1;
            upper = 1'b0;
            kicks = 0;
            gave_up = 1'b0;
            while (slots[idx][KEY_W] && !gave_up) begin
              if (kicks >= kick_limit) begin
                gave_up = 1'b1;
              end else begin
                evicted = slots[idx][KEY_W-1:0];
                slots[idx] = {1'b1, hand};
                hand = evicted;
                kicks++;
                upper = !upper;
                idx = upper ? second_of(hand) : first_of(hand);
              end
            end
            if (gave_up) begin
              rsp.status = ST_DROPPED;
              rsp.dropped_key = hand;
              drops++;
            end else begin
              slots[idx] = {1'b1, hand};
              rsp.status = ST_INSERTED;
              evict_inserts++;
            end
          end
        end
        CMD_CLEAR: begin
          clears++;
          wipe();
        end
        default: unused++;
      endcase
      owed_rsps.push_back(rsp);
    endfunction

    function void compare_result(cht_rsp_t got);
      cht_rsp_t want;
      if (owed_rsps.size() == 0) begin
        report($sformatf("unexpected response found=%0d status=%0d dropped_key=%0h",
                         got.found, got.status, got.dropped_key));
        return;
      end
      want = owed_rsps.pop_front();
      if (got.found !== want.found || got.status !== want.status ||
          got.dropped_key !== want.dropped_key)
        report($sformatf({"expected found=%0d status=%0d dropped_key=%0h, ",
                          "got found=%0d status=%0d dropped_key=%0h"},
                         want.found, want.status, want.dropped_key,
                         got.found, got.status, got.dropped_key));
    endfunction

    function void flush_owed();
      while (owed_rsps.size() > 0) begin
        report($sformatf("response never arrived, status=%0d", owed_rsps[0].status));
        void'(owed_rsps.pop_front());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cht_req_t in_req = '0;
  logic cfg_wr_en = 1'b0;
  logic [KICK_W-1:0] cfg_wr_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cht_rsp_t out_rsp;

  cuckoo_shadow shadow;
  logic [KEY_W-1:0] placed_keys [$];
  bit send_quiet, take_quiet;
  int hot_first, hot_second, hot_span;
  int settings_used;

  cuckoo_hash_table dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp(out_rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int idle_draw(bit quiet);
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic cht_req_t mk(logic [1:0] c, logic [31:0] k);
    cht_req_t r;
    r.cmd = c;
    r.key = k[KEY_W-1:0];
    return r;
  endfunction

  // Mostly keys crowded into a few slots so eviction chains form
  function automatic logic [KEY_W-1:0] draw_key();
    logic [31:0] k;
    int pick;
    pick = $urandom_range(0, 99);
    k = $urandom();
    if (pick < 55) begin
      k = (k / HQ) * HQ + (hot_second + $urandom_range(0, hot_span)) * HALF
          + hot_first + $urandom_range(0, hot_span);
    end else if (pick < 80 && placed_keys.size() > 0) begin
      k = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
    end else if (pick >= 95) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = '1;
        2: k = HALF - 1;
        default: k = HQ - 1;
      endcase
    end
    return k[KEY_W-1:0];
  endfunction

  function automatic cht_req_t draw_request();
    cht_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.key = draw_key();
    if (pick < 52) r.cmd = CMD_INSERT;
    else if (pick < 90) r.cmd = CMD_SEARCH;
    else if (pick < 94) r.cmd = CMD_CLEAR;
    else r.cmd = CMD_UNUSED;
    return r;
  endfunction

  // Leave valid up between back-to-back requests; drop it only for a gap
  task automatic send_request(input cht_req_t r);
    int gap;
    gap = idle_draw(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    shadow.apply_request(r);
    if (r.cmd == CMD_INSERT) begin
      placed_keys.push_back(r.key);
      if (placed_keys.size() > 48) void'(placed_keys.pop_front());
    end
  endtask

  task automatic wait_drained();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (shadow.owed_rsps.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_kick_limit(input logic [KICK_W-1:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow.kick_limit = v;
    settings_used++;
  endtask

  task automatic run_directed();
    send_quiet = $urandom_range(0, 1);
    take_quiet = $urandom_range(0, 1);
    send_request(mk(CMD_SEARCH, 0));
    send_request(mk(CMD_INSERT, 0));
    send_request(mk(CMD_INSERT, 0));
    send_request(mk(CMD_SEARCH, 0));
    send_request(mk(CMD_INSERT, 32'h7fff_ffff));
    send_request(mk(CMD_SEARCH, 32'h7fff_ffff));
    // three keys sharing both slots: the last one runs into the kick limit
    send_request(mk(CMD_INSERT, HQ));
    send_request(mk(CMD_INSERT, 2 * HQ));
    send_request(mk(CMD_SEARCH, 2 * HQ));
    // both slots of the third key are taken, so it starts an eviction chain
    send_request(mk(CMD_INSERT, 1));
    send_request(mk(CMD_INSERT, 1 + 2 * HALF));
    send_request(mk(CMD_INSERT, 1 + 2 * HALF + HQ));
    send_request(mk(CMD_SEARCH, 1));
    send_request(mk(CMD_SEARCH, 1 + 2 * HALF + HQ));
    send_request(mk(CMD_UNUSED, 32'h7fff_ffff));
    send_request(mk(CMD_UNUSED, 0));
    send_request(mk(CMD_CLEAR, 32'h7fff_ffff));
    send_request(mk(CMD_SEARCH, 0));
    // no evictions allowed: the inserted key itself is dropped
    set_kick_limit('0);
    send_request(mk(CMD_INSERT, 5));
    send_request(mk(CMD_INSERT, 5 + HQ));
    send_request(mk(CMD_INSERT, 5 + 2 * HQ));
    send_request(mk(CMD_SEARCH, 5 + 2 * HQ));
  endtask

  task automatic run_phase(input logic [KICK_W-1:0] limit, input int count);
    set_kick_limit(limit);
    hot_span = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) begin
      hot_first = HALF - 1 - hot_span;
      hot_second = HALF - 1 - hot_span;
    end else begin
      hot_first = $urandom_range(0, HALF - 1 - hot_span);
      hot_second = $urandom_range(0, HALF - 1 - hot_span);
    end
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
        take_quiet = ($urandom_range(0, 3) == 0);
      end
      send_request(draw_request());
    end
  endtask

  initial begin : take_results
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = idle_draw(take_quiet);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      shadow.compare_result(out_rsp);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    shadow = new();
    settings_used = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_phase('0, 120);
    run_phase('1, 40);
    run_phase(12'd3, 200);
    run_phase(12'd1, 140);
    run_phase(KICK_W'($urandom_range(0, 64)), 200);
    run_phase(KICKS_RESET, 150);
    wait_drained();
    repeat (16) @(posedge clk);
    shadow.flush_owed();
    $display("Ran %0d searches (%0d hits), %0d inserts, %0d clears, %0d unused commands",
             shadow.searches, shadow.hits, shadow.inserts, shadow.clears, shadow.unused);
    $display("Kick settings %0d, inserts placed by eviction %0d, kick-limit drops %0d, errors %0d",
             settings_used, shadow.evict_inserts, shadow.drops, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/cht_pkg.sv
design/cht_dp.sv
design/cht_ctrl.sv
design/cuckoo_hash_table.sv
design/cht_checker.sv
dv/cuckoo_hash_table_test.sv
